/* hw/rtl/hcbp_pkg.sv */
// Shared constants, codes and control structs of the Huffman code bit packer.
`timescale 1ns / 1ps

package hcbp_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int MAX_CODE_LEN = 32;
    localparam int BYTE_BITS    = 8;

    localparam int SYM_W   = $clog2(SYMBOL_COUNT);
    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int CNT_W   = 32;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 2;
    localparam int PCNT_W  = 3;
    localparam int ACC_W   = CODE_W + BYTE_BITS;
    localparam int ENTRY_W = CODE_W + LEN_W;
    localparam int CFG_IDX_W = 1;

    // Item actions
    localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ENCODE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FLUSH  = 2'd2;

    // Status and sticky error codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOCODE   = 2'd1;
    localparam logic [STAT_W-1:0] ST_LIMIT    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTREADY = 2'd3;

    // Result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_READY  = 1'd1;

    // Controller to datapath commands
    typedef struct packed {
        logic wr_tbl;     // write table entry from input payload
        logic rd_tbl;     // read table entry at input symbol
        logic set_nr;     // raise table-not-ready error
        logic set_nc;     // raise no-code error
        logic load_w;     // merge looked-up code behind pending bits
        logic emit_byte;  // send top byte of accumulator
        logic limit_err;  // raise limit error, drop pending bits
        logic keep_rem;   // park accumulator remainder as pending bits
        logic flush_chk;  // raise not-ready error at flush if clean
        logic pad_byte;   // send padded partial byte
        logic stat_item;  // send closing status item, clear packer
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic err_zero;
        logic tbl_ready;
        logic lookup_ok;
        logic wcnt_ge8;
        logic pend_nz;
        logic at_limit;
        logic out_free;
    } t_sts;

endpackage

/* hw/rtl/hcbp_if.sv */
// Channel interfaces: input items, result items and configuration writes.
`timescale 1ns / 1ps

interface hcbp_in_if;
    logic                             valid;
    logic                             ready;
    logic [hcbp_pkg::ACT_W-1:0]       action;
    logic [hcbp_pkg::SYM_W-1:0]       symbol;
    logic [hcbp_pkg::CODE_W-1:0]      code_bits;
    logic [hcbp_pkg::LEN_W-1:0]       code_len;

    modport source (output valid, action, symbol, code_bits, code_len, input ready);
    modport sink   (input valid, action, symbol, code_bits, code_len, output ready);
endinterface

interface hcbp_out_if;
    logic                             valid;
    logic                             ready;
    logic                             kind;
    logic [hcbp_pkg::BYTE_BITS-1:0]   out_byte;
    logic [hcbp_pkg::STAT_W-1:0]      status;
    logic [hcbp_pkg::CNT_W-1:0]       byte_count;
    logic                             last;

    modport source (output valid, kind, out_byte, status, byte_count, last, input ready);
    modport sink   (input valid, kind, out_byte, status, byte_count, last, output ready);
endinterface

interface hcbp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [hcbp_pkg::CFG_IDX_W-1:0]   index;
    logic [hcbp_pkg::CODE_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/hcbp_dpath.sv */
// Datapath: code table, bit accumulator, byte counter, error and result register.
`timescale 1ns / 1ps

module hcbp_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  hcbp_pkg::t_cmd                  i_cmd,
    output hcbp_pkg::t_sts                  o_sts,
    input  logic [hcbp_pkg::SYM_W-1:0]      i_symbol,
    input  logic [hcbp_pkg::CODE_W-1:0]     i_code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]      i_code_len,
    input  logic                            i_cfg_we,
    input  logic [hcbp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hcbp_pkg::CODE_W-1:0]     i_cfg_data,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_kind,
    output logic [hcbp_pkg::BYTE_BITS-1:0]  o_out_byte,
    output logic [hcbp_pkg::STAT_W-1:0]     o_status,
    output logic [hcbp_pkg::CNT_W-1:0]      o_byte_count,
    output logic                            o_last
);
    import hcbp_pkg::*;

    logic [ENTRY_W-1:0]      r_mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] r_tvld;
    logic [CODE_W-1:0]       r_rd_code;
    logic [LEN_W-1:0]        r_rd_len;
    logic                    r_rd_vld;

    logic [CNT_W-1:0]     r_limit;
    logic                 r_tready;
    logic [STAT_W-1:0]    r_err;
    logic [BYTE_BITS-1:0] r_pend;      // left aligned
    logic [PCNT_W-1:0]    r_pcnt;
    logic [CNT_W-1:0]     r_emitted;
    logic [ACC_W-1:0]     r_w;         // left aligned
    logic [LEN_W-1:0]     r_wcnt;

    logic                 r_ov;
    logic                 r_okind;
    logic [BYTE_BITS-1:0] r_obyte;
    logic [STAT_W-1:0]    r_ostat;
    logic [CNT_W-1:0]     r_ocnt;
    logic                 r_olast;

    logic [LEN_W-1:0]  len_clamp;
    logic [LEN_W-1:0]  code_sh;
    logic [CODE_W-1:0] code_al;
    logic [ACC_W-1:0]  n_w;
    logic [LEN_W-1:0]  n_wcnt;
    logic [CNT_W-1:0]  emitted_inc;
    logic              byte_last;
    logic              out_free;
    logic              out_load;

    assign len_clamp = (i_code_len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : i_code_len;

    // table store and registered lookup
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_tbl) begin
            r_mem[i_symbol] <= {len_clamp, i_code_bits};
        end
        if (i_cmd.rd_tbl) begin
            {r_rd_len, r_rd_code} <= r_mem[i_symbol];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvld   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.wr_tbl) begin
                r_tvld[i_symbol] <= 1'b1;
            end
            if (i_cmd.rd_tbl) begin
                r_rd_vld <= r_tvld[i_symbol];
            end
        end
    end

    // merge code behind the pending bits
    assign code_sh = LEN_W'(CODE_W) - r_rd_len;
    assign code_al = r_rd_code << code_sh;
    assign n_w     = {r_pend, {CODE_W{1'b0}}} | ({code_al, {BYTE_BITS{1'b0}}} >> r_pcnt);
    assign n_wcnt  = LEN_W'(r_pcnt) + r_rd_len;

    assign emitted_inc = r_emitted + CNT_W'(1);
    assign byte_last   = (r_wcnt < LEN_W'(2 * BYTE_BITS)) || (emitted_inc == r_limit);
    assign out_free    = !r_ov || i_out_ready;
    assign out_load    = i_cmd.emit_byte || i_cmd.pad_byte || i_cmd.stat_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= '1;
            r_tready  <= 1'b0;
            r_err     <= ST_OK;
            r_pend    <= '0;
            r_pcnt    <= '0;
            r_emitted <= '0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_OUTPUT_LIMIT: r_limit  <= i_cfg_data;
                    REG_TABLE_READY:  r_tready <= i_cfg_data[0];
                    default: ;
                endcase
            end

            priority if (i_cmd.set_nr) begin
                r_err <= ST_NOTREADY;
            end else if (i_cmd.set_nc) begin
                r_err <= ST_NOCODE;
            end else if (i_cmd.flush_chk) begin
                if (r_err == ST_OK && !r_tready) begin
                    r_err <= ST_NOTREADY;
                end
            end else if (i_cmd.limit_err) begin
                r_err  <= ST_LIMIT;
                r_pend <= '0;
                r_pcnt <= '0;
            end else if (i_cmd.load_w) begin
                r_pend <= '0;
                r_pcnt <= '0;
            end else if (i_cmd.keep_rem) begin
                r_pend <= r_w[ACC_W-1 -: BYTE_BITS];
                r_pcnt <= r_wcnt[PCNT_W-1:0];
            end else if (i_cmd.emit_byte || i_cmd.pad_byte) begin
                r_emitted <= emitted_inc;
                if (i_cmd.pad_byte) begin
                    r_pend <= '0;
                    r_pcnt <= '0;
                end
            end else if (i_cmd.stat_item) begin
                r_err     <= ST_OK;
                r_pend    <= '0;
                r_pcnt    <= '0;
                r_emitted <= '0;
            end

            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // accumulator and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_w) begin
            r_w    <= n_w;
            r_wcnt <= n_wcnt;
        end else if (i_cmd.emit_byte) begin
            r_w    <= r_w << BYTE_BITS;
            r_wcnt <= r_wcnt - LEN_W'(BYTE_BITS);
        end

        priority if (i_cmd.emit_byte) begin
            r_okind <= KIND_DATA;
            r_obyte <= r_w[ACC_W-1 -: BYTE_BITS];
            r_ostat <= ST_OK;
            r_ocnt  <= emitted_inc;
            r_olast <= byte_last;
        end else if (i_cmd.pad_byte) begin
            r_okind <= KIND_DATA;
            r_obyte <= r_pend;
            r_ostat <= ST_OK;
            r_ocnt  <= emitted_inc;
            r_olast <= 1'b0;
        end else if (i_cmd.stat_item) begin
            r_okind <= KIND_STATUS;
            r_obyte <= '0;
            r_ostat <= r_err;
            r_ocnt  <= r_emitted;
            r_olast <= 1'b1;
        end
    end

    assign o_sts.err_zero  = (r_err == ST_OK);
    assign o_sts.tbl_ready = r_tready;
    assign o_sts.lookup_ok = r_rd_vld && (r_rd_len != '0);
    assign o_sts.wcnt_ge8  = (r_wcnt >= LEN_W'(BYTE_BITS));
    assign o_sts.pend_nz   = (r_pcnt != '0);
    assign o_sts.at_limit  = (r_emitted >= r_limit);
    assign o_sts.out_free  = out_free;

    assign o_out_valid  = r_ov;
    assign o_kind       = r_okind;
    assign o_out_byte   = r_obyte;
    assign o_status     = r_ostat;
    assign o_byte_count = r_ocnt;
    assign o_last       = r_olast;

endmodule

/* hw/rtl/hcbp_ctrl.sv */
// Controller: sequences table access, byte packing and flush for one item at a time.
`timescale 1ns / 1ps

module hcbp_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [hcbp_pkg::ACT_W-1:0]  i_action,
    output logic                        o_in_ready,
    input  hcbp_pkg::t_sts              i_sts,
    output hcbp_pkg::t_cmd              o_cmd
);
    import hcbp_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOKUP = 3'd1;
    localparam logic [2:0] S_EMIT   = 3'd2;
    localparam logic [2:0] S_FPAD   = 3'd3;
    localparam logic [2:0] S_STAT   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign acc        = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    unique case (i_action)
                        ACT_LOAD: o_cmd.wr_tbl = 1'b1;
                        ACT_ENCODE: begin
                            if (i_sts.err_zero) begin
                                if (!i_sts.tbl_ready) begin
                                    o_cmd.set_nr = 1'b1;
                                end else begin
                                    o_cmd.rd_tbl = 1'b1;
                                    n_state      = S_LOOKUP;
                                end
                            end
                        end
                        ACT_FLUSH: begin
                            o_cmd.flush_chk = 1'b1;
                            n_state         = S_FPAD;
                        end
                        default: ;
                    endcase
                end
            end
            S_LOOKUP: begin
                if (!i_sts.lookup_ok) begin
                    o_cmd.set_nc = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.load_w = 1'b1;
                    n_state      = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.wcnt_ge8) begin
                    if (i_sts.at_limit) begin
                        o_cmd.limit_err = 1'b1;
                        n_state         = S_IDLE;
                    end else if (i_sts.out_free) begin
                        o_cmd.emit_byte = 1'b1;
                    end
                end else begin
                    o_cmd.keep_rem = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_FPAD: begin
                if (i_sts.err_zero && i_sts.pend_nz) begin
                    if (i_sts.at_limit) begin
                        o_cmd.limit_err = 1'b1;
                        n_state         = S_STAT;
                    end else if (i_sts.out_free) begin
                        o_cmd.pad_byte = 1'b1;
                        n_state        = S_STAT;
                    end
                end else begin
                    n_state = S_STAT;
                end
            end
            S_STAT: begin
                if (i_sts.out_free) begin
                    o_cmd.stat_item = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hw/rtl/huffman_code_bit_packer_core.sv */
// Top level of the Huffman code bit packer: controller, datapath and channel wiring.
`timescale 1ns / 1ps
//
// Channel   Dir  Payload                                     Transaction
// i_in      in   action, symbol, code_bits, code_len         valid && ready
// o_out     out  kind, out_byte, status, byte_count, last    valid && ready
// i_cfg     in   index (0 output_limit, 1 table_ready), data valid && ready
//
// One item at a time. A load writes one table entry. An encode steps through the
// registered table lookup, the merge into the accumulator and a drain of up to
// 4 bytes, one byte per cycle while the result register is free; an encode
// dropped for a pending error or an unready table stays in idle, and one whose
// symbol has no code ends after the lookup. A flush pads, then sends status.
// A stalled output holds the packer at the next byte; the result register lets
// one finished transaction wait while the next input is taken.
// Reset is synchronous; the table's valid bits clear at once, no sweep.
//

module huffman_code_bit_packer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hcbp_in_if.sink     i_in,
    hcbp_out_if.source  o_out,
    hcbp_cfg_if.sink    i_cfg
);
    import hcbp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Configuration writes land directly in the datapath registers.
    assign i_cfg.ready = 1'b1;

    // Controller: decode action, step through lookup, drain and flush.
    hcbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_action   (i_in.action),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: table memory, accumulator, counter, sticky error, result register.
    hcbp_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_symbol     (i_in.symbol),
        .i_code_bits  (i_in.code_bits),
        .i_code_len   (i_in.code_len),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_kind       (o_out.kind),
        .o_out_byte   (o_out.out_byte),
        .o_status     (o_out.status),
        .o_byte_count (o_out.byte_count),
        .o_last       (o_out.last)
    );

endmodule
